@@ design/kdsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsc_pkg: shared types, constants and the byte decode function
// Holds the result item layout, the hand-off bundle from the line parser to
// the result queue, the mode tables and the keyed byte decode.
// ----------------------------------------------------------------------------
package kdsc_pkg;

    localparam logic [7:0] CHR_QMARK = 8'h3F;   // '?'
    localparam logic [7:0] CHR_HASH  = 8'h23;   // '#'

    // Bytes of a keyed body inside this range are decoded
    localparam logic [7:0] BODY_LO = 8'h20;
    localparam logic [7:0] BODY_HI = 8'h7B;

    // Decoded bytes fold into FOLD_LO..FOLD_HI in steps of FOLD_STEP
    localparam logic signed [9:0] FOLD_LO   = 10'sh020;
    localparam logic signed [9:0] FOLD_HI   = 10'sh07C;
    localparam logic signed [9:0] FOLD_STEP = 10'sh05C;
    localparam logic signed [9:0] REFLECT   = 10'sh09C;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        SWAP1,      // even +1, odd -1
        SWAP2,      // 1 -> +1, 2 -> -1
        SWAP3,      // 0 -> +3, 3 -> -3
        SWAP4,      // 0,1 -> +2, 2,3 -> -2
        SWAP5,      // 0 -> +2, 2 -> -2
        SWAP6       // 1 -> +2, 3 -> -2
    } swap_t;

    // Per mode: swap rule, and the magnitude of the key offset.
    // Odd modes offset by the second key, even modes by the first.
    localparam swap_t SWAP_OF_MODE [8] = '{
        SWAP2, SWAP1, SWAP6, SWAP4, SWAP2, SWAP4, SWAP3, SWAP5
    };
    localparam logic [7:0] KEY_BIAS [8] = '{
        8'h03, 8'h14, 8'h45, 8'h07, 8'h35, 8'h37, 8'h20, 8'h13
    };

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       ends_line;
    } result_t;

    // Up to two results handed to the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [7:0] decode_byte(input logic [7:0] c,
                                               input logic [7:0] k1,
                                               input logic [7:0] k2);
        logic [2:0]        mode;
        logic [1:0]        lo;
        logic [7:0]        sw;
        logic [7:0]        key;
        logic signed [9:0] t;
        mode = k1[2:0] + k2[2:0];
        lo   = c[1:0];
        key  = mode[0] ? k2 : k1;
        case (SWAP_OF_MODE[mode])
            SWAP1: sw = lo[0] ? c - 8'd1 : c + 8'd1;
            SWAP2: sw = (lo == 2'd1) ? c + 8'd1 : ((lo == 2'd2) ? c - 8'd1 : c);
            SWAP3: sw = (lo == 2'd0) ? c + 8'd3 : ((lo == 2'd3) ? c - 8'd3 : c);
            SWAP4: sw = lo[1] ? c - 8'd2 : c + 8'd2;
            SWAP5: sw = (lo == 2'd0) ? c + 8'd2 : ((lo == 2'd2) ? c - 8'd2 : c);
            SWAP6: sw = (lo == 2'd1) ? c + 8'd2 : ((lo == 2'd3) ? c - 8'd2 : c);
            default: sw = c;
        endcase
        // Reflect, then subtract the mode bias and the signed key
        t = REFLECT - signed'({2'b00, sw}) - signed'({2'b00, KEY_BIAS[mode]})
            - signed'({{2{key[7]}}, key});
        for (int i = 0; i < 3; i++) begin
            if (t > FOLD_HI) t = t - FOLD_STEP;
        end
        for (int i = 0; i < 3; i++) begin
            if (t < FOLD_LO) t = t + FOLD_STEP;
        end
        return t[7:0];
    endfunction

endpackage

@@ design/kdsc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsc_parser: input register and line header state machine
// Registers each incoming item, tracks the line header and key bytes, and
// turns one item into zero, one or two results for the queue.
// ----------------------------------------------------------------------------
module kdsc_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] in_byte
    input  logic                s_tlast,    // line_end
    input  logic                q_room,
    output kdsc_pkg::push_t     push
);

    typedef enum logic [2:0] {
        PH_START,
        PH_QMARK,
        PH_KEY1,
        PH_KEY2,
        PH_KEYED,
        PH_PLAIN
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      key1_reg, key2_reg;
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    logic            consume;
    logic [1:0]      n_raw;
    kdsc_pkg::result_t r0, r1;
    logic            in_body;

    assign consume  = in_valid_reg & q_room;
    assign s_tready = ~in_valid_reg | consume;
    assign in_body  = (in_byte_reg >= kdsc_pkg::BODY_LO) &&
                      (in_byte_reg <= kdsc_pkg::BODY_HI);

    always_comb begin
        n_raw      = 2'd1;
        r0         = '{data: in_byte_reg, has_byte: 1'b1, ends_line: in_last_reg};
        r1         = '{data: in_byte_reg, has_byte: 1'b1, ends_line: in_last_reg};
        phase_next = PH_PLAIN;
        case (phase_reg)
            PH_QMARK: begin
                if (in_byte_reg == kdsc_pkg::CHR_HASH) begin
                    n_raw      = {1'b0, in_last_reg};
                    r0         = '{data: 8'h00, has_byte: 1'b0, ends_line: 1'b1};
                    phase_next = PH_KEY1;
                end else begin
                    // release the held '?' ahead of this byte
                    n_raw = 2'd2;
                    r0    = '{data: kdsc_pkg::CHR_QMARK, has_byte: 1'b1,
                              ends_line: 1'b0};
                end
            end
            PH_KEY1, PH_KEY2: begin
                n_raw      = {1'b0, in_last_reg};
                r0         = '{data: 8'h00, has_byte: 1'b0, ends_line: 1'b1};
                phase_next = (phase_reg == PH_KEY1) ? PH_KEY2 : PH_KEYED;
            end
            PH_KEYED: begin
                if (in_body) begin
                    r0.data = kdsc_pkg::decode_byte(in_byte_reg, key1_reg, key2_reg);
                end
                phase_next = PH_KEYED;
            end
            PH_PLAIN: phase_next = PH_PLAIN;
            default: begin
                if (in_byte_reg == kdsc_pkg::CHR_QMARK) begin
                    // hold the '?' until the next byte decides
                    n_raw      = {1'b0, in_last_reg};
                    r0         = '{data: kdsc_pkg::CHR_QMARK, has_byte: 1'b1,
                                   ends_line: 1'b1};
                    phase_next = PH_QMARK;
                end
            end
        endcase
        if (in_last_reg) phase_next = PH_START;
    end

    assign push.count  = consume ? n_raw : 2'd0;
    assign push.first  = r0;
    assign push.second = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            key1_reg     <= 8'h00;
            key2_reg     <= 8'h00;
            in_valid_reg <= 1'b0;
        end else begin
            if (consume) begin
                phase_reg <= phase_next;
                if (phase_reg == PH_KEY1) key1_reg <= in_byte_reg;
                if (phase_reg == PH_KEY2) key2_reg <= in_byte_reg;
            end
            if (s_tready) in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    a_keyed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && phase_reg == PH_KEYED && in_body) |->
        (push.first.data >= 8'h20 && push.first.data <= 8'h7C))
        else $error("decoded byte outside the folded range");

    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_last_reg) |=> (phase_reg == PH_START))
        else $error("line end did not return to start of line");

endmodule

@@ design/kdsc_res_q.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsc_res_q: result queue
// Small register queue that takes up to two results a cycle while it has room
// for two, and hands out one result a cycle on the output stream while m_tready is high.
// ----------------------------------------------------------------------------
module kdsc_res_q (
    input  logic                aclk,
    input  logic                aresetn,
    input  kdsc_pkg::push_t     push,
    output logic                q_room,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [7:0] out_byte
    output logic                m_tuser,    // has_byte
    output logic                m_tlast     // ends_line
);

    kdsc_pkg::result_t            entry_reg [kdsc_pkg::Q_DEPTH];
    logic [kdsc_pkg::Q_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [kdsc_pkg::Q_CW-1:0]    count_reg, count_next;
    logic                         pop;
    kdsc_pkg::result_t            head;

    assign head     = entry_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = head.data;
    assign m_tuser  = head.has_byte;
    assign m_tlast  = head.ends_line;
    assign pop      = m_tvalid & m_tready;
    // room for two more, whatever leaves this cycle
    assign q_room   = (count_reg <= kdsc_pkg::Q_CW'(kdsc_pkg::Q_DEPTH - 2));

    assign count_next = count_reg + kdsc_pkg::Q_CW'(push.count)
                        - kdsc_pkg::Q_CW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + kdsc_pkg::Q_AW'(push.count);
            if (pop) rd_ptr_reg <= rd_ptr_reg + kdsc_pkg::Q_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2) entry_reg[wr_ptr_reg + kdsc_pkg::Q_AW'(1)] <= push.second;
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= kdsc_pkg::Q_CW'(kdsc_pkg::Q_DEPTH))
        else $error("result queue holds more than its depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |->
        (count_reg <= kdsc_pkg::Q_CW'(kdsc_pkg::Q_DEPTH - 2)))
        else $error("results pushed without room for two");

endmodule

@@ design/keyed_text_descrambler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_text_descrambler: keyed text line descrambler, one byte per item
// Streams text bytes in, decodes keyed lines and streams results out.
// ----------------------------------------------------------------------------
// Each input item is one byte of a text line, with s_tlast marking the last
// byte of the line. A line that opens with "?#" is keyed: its third and
// fourth bytes are the key bytes, none of the four header bytes is emitted,
// and each later byte from 0x20 to 0x7B is decoded; other bytes pass as they
// are. A line without the header passes through whole, a leading '?' being
// held one item until the next byte shows whether a header follows. On the
// result side m_tuser is 1 when m_tdata carries a byte; a result with
// m_tuser low (and m_tdata zero) is a bare line end, sent when a line ends
// inside its header. m_tlast marks the last result of each line.
// Rate: one item is accepted every cycle while results drain at one a cycle.
// An item is held in the input register on acceptance and decoded from it,
// once the queue has room, into a four-entry result queue that registers
// its results before they are offered. Most items give one result; a '?'
// not followed by '#' releases two results in one item, and the header
// items give none unless the line ends there. The output port drains one
// result a cycle while m_tready is high, so the sustained rate is set by
// the result queue: one result per cycle on the output side. The queue
// takes a decoded item only when it has room for two results, and
// back-pressure reaches s_tready through the single input register.
// ----------------------------------------------------------------------------
module keyed_text_descrambler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tuser,    // has_byte
    output logic        m_tlast     // ends_line
);

    kdsc_pkg::push_t push;
    logic            q_room;

    // Header tracking, key capture and byte decode
    kdsc_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_room   (q_room),
        .push     (push)
    );

    // Hold results until the output side takes them
    kdsc_res_q u_res_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .q_room   (q_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
